// ===== rtl/dnamc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnamc_pkg
// Shared types and constants for the multi-pattern DNA match counter.
// ----------------------------------------------------------------------------
package dnamc_pkg;

    typedef enum logic [2:0] {
        ACT_PATTERN_CHAR = 3'd0,
        ACT_BUILD        = 3'd1,
        ACT_TEXT_CHAR    = 3'd2,
        ACT_READ         = 3'd3,
        ACT_CLEAR        = 3'd4
    } t_action;

    typedef enum logic [4:0] {
        S_INIT,
        S_IDLE,
        S_LD_RD,
        S_LD_CLR,
        S_LD_END,
        S_LD_NP,
        S_B_POP,
        S_B_U,
        S_B_FU,
        S_B_CH,
        S_B_CHD,
        S_B_T,
        S_B_TD,
        S_B_FP,
        S_T_RD,
        S_T_D,
        S_T_F,
        S_C_NP,
        S_C_ND,
        S_C_CNT,
        S_R_A,
        S_R_C
    } t_state;

    localparam logic [7:0] CH_A = 8'h41;
    localparam logic [7:0] CH_T = 8'h54;
    localparam logic [7:0] CH_G = 8'h47;
    localparam logic [7:0] CH_Z = 8'h5A;

    localparam logic [1:0] EDGE_A     = 2'd0;
    localparam logic [1:0] EDGE_T     = 2'd1;
    localparam logic [1:0] EDGE_G     = 2'd2;
    localparam logic [1:0] EDGE_OTHER = 2'd3;

    function automatic logic [1:0] edge_of(input logic [7:0] ch);
        logic [1:0] e;
        case (ch)
            CH_A:    e = EDGE_A;
            CH_T:    e = EDGE_T;
            CH_G:    e = EDGE_G;
            default: e = EDGE_OTHER;
        endcase
        return e;
    endfunction

endpackage

// ===== rtl/dna_multi_pattern_match_counter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dna_multi_pattern_match_counter
// Aho-Corasick pattern counter over the edge classes A, T, G and other, held in memories.
// ----------------------------------------------------------------------------
// Steps: a pattern char reads its child slot, may allocate and clear a new
// node, then closes the pattern on its last char. A text char reads a child
// slot and follows failure steps, then walks the output chain node by node.
// Build pops each node, scans its edge slots and follows fail steps per child.
// Reset and clear zero the root's child entries; busy is high meanwhile. A
// read item's strobe comes from a registered flag. The receiver cannot stall.
// ----------------------------------------------------------------------------
module dna_multi_pattern_match_counter #(
    parameter int MAX_NODES    = 4096,
    parameter int MAX_PATTERNS = 1024,
    parameter int COUNT_BITS   = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_action,
    input  logic [7:0]  i_char_code,
    input  logic        i_pattern_end,
    input  logic [10:0] i_pattern_number,
    output logic        o_valid,
    output logic [31:0] o_match_count,
    output logic        o_table_full
);
    import dnamc_pkg::*;

    localparam int NW   = $clog2(MAX_NODES);
    localparam int PW   = $clog2(MAX_PATTERNS + 1);
    localparam int CW   = COUNT_BITS;
    localparam int CMPW = (PW > 11) ? PW : 11;
    localparam int PDEP = MAX_PATTERNS + 1;

    // memories
    logic [NW-1:0] m_child [MAX_NODES*4];
    logic [NW-1:0] m_fail  [MAX_NODES];
    logic [PW-1:0] m_np    [MAX_NODES];
    logic [PW-1:0] m_alias [PDEP];
    logic [CW-1:0] m_cnt   [PDEP];
    logic [NW-1:0] m_queue [MAX_NODES];

    logic          w_c_we, w_f_we, w_np_we, w_a_we, w_cnt_we, w_q_we;
    logic [NW+1:0] w_c_wa, w_c_ra;
    logic [NW-1:0] w_c_wd, w_f_wa, w_f_wd, w_f_ra, w_np_wa, w_np_ra, w_q_wa, w_q_wd, w_q_ra;
    logic [PW-1:0] w_np_wd, w_a_wa, w_a_wd, w_a_ra, w_cnt_wa, w_cnt_ra;
    logic [CW-1:0] w_cnt_wd;
    logic [NW-1:0] r_c_rd, r_f_rd, r_q_rd;
    logic [PW-1:0] r_np_rd, r_a_rd;
    logic [CW-1:0] r_cnt_rd;

    always_ff @(posedge i_clk) begin
        if (w_c_we) m_child[w_c_wa] <= w_c_wd;
        r_c_rd <= m_child[w_c_ra];
    end
    always_ff @(posedge i_clk) begin
        if (w_f_we) m_fail[w_f_wa] <= w_f_wd;
        r_f_rd <= m_fail[w_f_ra];
    end
    always_ff @(posedge i_clk) begin
        if (w_np_we) m_np[w_np_wa] <= w_np_wd;
        r_np_rd <= m_np[w_np_ra];
    end
    always_ff @(posedge i_clk) begin
        if (w_a_we) m_alias[w_a_wa] <= w_a_wd;
        r_a_rd <= m_alias[w_a_ra];
    end
    always_ff @(posedge i_clk) begin
        if (w_cnt_we) m_cnt[w_cnt_wa] <= w_cnt_wd;
        r_cnt_rd <= m_cnt[w_cnt_ra];
    end
    always_ff @(posedge i_clk) begin
        if (w_q_we) m_queue[w_q_wa] <= w_q_wd;
        r_q_rd <= m_queue[w_q_ra];
    end

    // control and payload registers
    t_state        r_state, n_state;
    logic [NW:0]   r_nodes_used, n_nodes_used;
    logic [PW-1:0] r_loaded, n_loaded;
    logic [NW-1:0] r_cursor, n_cursor;
    logic          r_ovf, n_ovf;
    logic [NW-1:0] r_load_node, n_load_node;
    logic          r_load_bad, n_load_bad;
    logic [NW:0]   r_head, n_head, r_tail, n_tail;
    logic          r_valid, n_valid;
    logic [1:0]    r_edge, n_edge, r_i, n_i;
    logic          r_last, n_last;
    logic [NW-1:0] r_u, n_u, r_fu, n_fu, r_c, n_c, r_p, n_p, r_t, n_t, r_nx, n_nx;
    logic [PW-1:0] r_pidx, n_pidx;
    logic [CW-1:0] r_count, n_count;
    logic          r_full, n_full;

    logic          w_go, w_in_alpha, w_rd_ok;
    logic [PW-1:0] w_new_idx, w_req_idx;
    logic [63:0]   w_cnt64;

    assign w_go       = start && (r_state == S_IDLE);
    assign w_in_alpha = (i_char_code >= CH_A) && (i_char_code <= CH_Z);
    assign w_rd_ok    = (i_pattern_number != 11'd0)
                     && (CMPW'(i_pattern_number) <= CMPW'(r_loaded));
    assign w_new_idx  = r_loaded + PW'(1);
    assign w_req_idx  = PW'(i_pattern_number);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_INIT;
            r_nodes_used <= (NW+1)'(1);
            r_loaded     <= '0;
            r_cursor     <= '0;
            r_ovf        <= 1'b0;
            r_load_node  <= '0;
            r_load_bad   <= 1'b0;
            r_head       <= '0;
            r_tail       <= '0;
            r_valid      <= 1'b0;
            r_i          <= '0;
        end else begin
            r_state      <= n_state;
            r_nodes_used <= n_nodes_used;
            r_loaded     <= n_loaded;
            r_cursor     <= n_cursor;
            r_ovf        <= n_ovf;
            r_load_node  <= n_load_node;
            r_load_bad   <= n_load_bad;
            r_head       <= n_head;
            r_tail       <= n_tail;
            r_valid      <= n_valid;
            r_i          <= n_i;
        end
    end

    always_ff @(posedge i_clk) begin
        r_edge  <= n_edge;
        r_last  <= n_last;
        r_u     <= n_u;
        r_fu    <= n_fu;
        r_c     <= n_c;
        r_p     <= n_p;
        r_t     <= n_t;
        r_nx    <= n_nx;
        r_pidx  <= n_pidx;
        r_count <= n_count;
        r_full  <= n_full;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_INIT: if (r_i == 2'd3) n_state = S_IDLE;
            S_IDLE: begin
                if (w_go) begin
                    case (i_action)
                        ACT_PATTERN_CHAR: n_state = r_load_bad ? S_LD_END : S_LD_RD;
                        ACT_BUILD:        n_state = S_B_POP;
                        ACT_TEXT_CHAR:    n_state = w_in_alpha ? S_T_RD : S_IDLE;
                        ACT_READ:         n_state = w_rd_ok ? S_R_A : S_IDLE;
                        ACT_CLEAR:        n_state = S_INIT;
                        default:          n_state = S_IDLE;
                    endcase
                end
            end
            S_LD_RD: begin
                if (r_c_rd == '0 && r_nodes_used < (NW+1)'(MAX_NODES)) n_state = S_LD_CLR;
                else n_state = S_LD_END;
            end
            S_LD_CLR: if (r_i == 2'd3) n_state = S_LD_END;
            S_LD_END: begin
                if (r_last && r_loaded < PW'(MAX_PATTERNS) && !r_load_bad) n_state = S_LD_NP;
                else n_state = S_IDLE;
            end
            S_LD_NP: n_state = S_IDLE;
            S_B_POP: n_state = (r_head == r_tail) ? S_IDLE : S_B_U;
            S_B_U:   n_state = S_B_FU;
            S_B_FU:  n_state = S_B_CH;
            S_B_CH:  n_state = S_B_CHD;
            S_B_CHD: begin
                if (r_c_rd != '0 && r_u != '0) n_state = S_B_T;
                else n_state = (r_i == 2'd3) ? S_B_POP : S_B_CH;
            end
            S_B_T:   n_state = S_B_TD;
            S_B_TD: begin
                if (r_c_rd == '0 && r_p != '0) n_state = S_B_FP;
                else n_state = (r_i == 2'd3) ? S_B_POP : S_B_CH;
            end
            S_B_FP:  n_state = S_B_T;
            S_T_RD:  n_state = S_T_D;
            S_T_D: begin
                if (r_c_rd == '0 && r_p != '0) n_state = S_T_F;
                else n_state = (r_c_rd == '0) ? S_IDLE : S_C_NP;
            end
            S_T_F:   n_state = S_T_RD;
            S_C_NP:  n_state = S_C_ND;
            S_C_ND: begin
                if (r_np_rd != '0) n_state = S_C_CNT;
                else n_state = (r_f_rd == '0) ? S_IDLE : S_C_NP;
            end
            S_C_CNT: n_state = (r_nx == '0) ? S_IDLE : S_C_NP;
            S_R_A:   n_state = S_R_C;
            S_R_C:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and memory ports
    always_comb begin
        n_nodes_used = r_nodes_used;
        n_loaded     = r_loaded;
        n_cursor     = r_cursor;
        n_ovf        = r_ovf;
        n_load_node  = r_load_node;
        n_load_bad   = r_load_bad;
        n_head       = r_head;
        n_tail       = r_tail;
        n_valid      = 1'b0;
        n_edge       = r_edge;
        n_i          = r_i;
        n_last       = r_last;
        n_u          = r_u;
        n_fu         = r_fu;
        n_c          = r_c;
        n_p          = r_p;
        n_t          = r_t;
        n_nx         = r_nx;
        n_pidx       = r_pidx;
        n_count      = r_count;
        n_full       = r_full;
        w_c_we = 1'b0; w_c_wa = '0; w_c_wd = '0; w_c_ra = '0;
        w_f_we = 1'b0; w_f_wa = '0; w_f_wd = '0; w_f_ra = '0;
        w_np_we = 1'b0; w_np_wa = '0; w_np_wd = '0; w_np_ra = '0;
        w_a_we = 1'b0; w_a_wa = '0; w_a_wd = '0; w_a_ra = '0;
        w_cnt_we = 1'b0; w_cnt_wa = '0; w_cnt_wd = '0; w_cnt_ra = '0;
        w_q_we = 1'b0; w_q_wa = '0; w_q_wd = '0; w_q_ra = '0;
        case (r_state)
            S_INIT: begin
                // clear the root's children; deeper nodes are cleared on allocation
                w_c_we = 1'b1;
                w_c_wa = {NW'(0), r_i};
                n_i    = r_i + 2'd1;
            end
            S_IDLE: begin
                if (start) begin
                    case (i_action)
                        ACT_PATTERN_CHAR: begin
                            n_edge = edge_of(i_char_code);
                            n_last = i_pattern_end;
                            w_c_ra = {r_load_node, edge_of(i_char_code)};
                        end
                        ACT_BUILD: begin
                            w_q_we   = 1'b1;
                            w_q_wa   = '0;
                            w_q_wd   = '0;
                            n_head   = '0;
                            n_tail   = (NW+1)'(1);
                            n_cursor = '0;
                        end
                        ACT_TEXT_CHAR: begin
                            if (w_in_alpha) begin
                                n_edge = edge_of(i_char_code);
                                n_p    = r_cursor;
                            end else begin
                                n_cursor = '0;
                            end
                        end
                        ACT_READ: begin
                            if (w_rd_ok) begin
                                w_a_ra = w_req_idx;
                                n_pidx = w_req_idx;
                            end else begin
                                n_valid = 1'b1;
                                n_count = '0;
                                n_full  = r_ovf;
                            end
                        end
                        ACT_CLEAR: begin
                            n_nodes_used = (NW+1)'(1);
                            n_loaded     = '0;
                            n_cursor     = '0;
                            n_ovf        = 1'b0;
                            n_load_node  = '0;
                            n_load_bad   = 1'b0;
                            n_i          = '0;
                        end
                        default: ;
                    endcase
                end
            end
            S_LD_RD: begin
                if (r_c_rd != '0) begin
                    n_load_node = r_c_rd;
                end else if (r_nodes_used < (NW+1)'(MAX_NODES)) begin
                    w_c_we       = 1'b1;
                    w_c_wa       = {r_load_node, r_edge};
                    w_c_wd       = r_nodes_used[NW-1:0];
                    w_f_we       = 1'b1;
                    w_f_wa       = r_nodes_used[NW-1:0];
                    w_np_we      = 1'b1;
                    w_np_wa      = r_nodes_used[NW-1:0];
                    n_load_node  = r_nodes_used[NW-1:0];
                    n_nodes_used = r_nodes_used + (NW+1)'(1);
                    n_i          = '0;
                end else begin
                    n_ovf      = 1'b1;
                    n_load_bad = 1'b1;
                end
            end
            S_LD_CLR: begin
                w_c_we = 1'b1;
                w_c_wa = {r_load_node, r_i};
                n_i    = r_i + 2'd1;
            end
            S_LD_END: begin
                if (r_last) begin
                    if (r_loaded >= PW'(MAX_PATTERNS)) begin
                        n_ovf = 1'b1;
                    end else begin
                        n_loaded = w_new_idx;
                        n_pidx   = w_new_idx;
                        w_cnt_we = 1'b1;
                        w_cnt_wa = w_new_idx;
                        if (r_load_bad) begin
                            w_a_we = 1'b1;
                            w_a_wa = w_new_idx;
                        end
                        w_np_ra = r_load_node;
                    end
                    // hold load_node for the pattern lookup in the next state
                    if (r_loaded >= PW'(MAX_PATTERNS) || r_load_bad) n_load_node = '0;
                    n_load_bad = 1'b0;
                end
            end
            S_LD_NP: begin
                w_a_we = 1'b1;
                w_a_wa = r_pidx;
                w_a_wd = r_np_rd;
                if (r_np_rd == '0) begin
                    w_np_we = 1'b1;
                    w_np_wa = r_load_node;
                    w_np_wd = r_pidx;
                end
                n_load_node = '0;
            end
            S_B_POP: begin
                w_q_ra = r_head[NW-1:0];
                if (r_head != r_tail) n_head = r_head + (NW+1)'(1);
            end
            S_B_U: begin
                n_u    = r_q_rd;
                w_f_ra = r_q_rd;
                n_i    = '0;
            end
            S_B_FU: n_fu = r_f_rd;
            S_B_CH: w_c_ra = {r_u, r_i};
            S_B_CHD: begin
                n_c = r_c_rd;
                if (r_c_rd != '0 && r_u != '0) begin
                    n_p = r_fu;
                end else begin
                    if (r_c_rd != '0) begin
                        w_f_we = 1'b1;
                        w_f_wa = r_c_rd;
                        w_q_we = 1'b1;
                        w_q_wa = r_tail[NW-1:0];
                        w_q_wd = r_c_rd;
                        n_tail = r_tail + (NW+1)'(1);
                    end
                    n_i = r_i + 2'd1;
                end
            end
            S_B_T: w_c_ra = {r_p, r_i};
            S_B_TD: begin
                if (r_c_rd == '0 && r_p != '0) begin
                    w_f_ra = r_p;
                end else begin
                    w_f_we = 1'b1;
                    w_f_wa = r_c;
                    w_f_wd = r_c_rd;
                    w_q_we = 1'b1;
                    w_q_wa = r_tail[NW-1:0];
                    w_q_wd = r_c;
                    n_tail = r_tail + (NW+1)'(1);
                    n_i    = r_i + 2'd1;
                end
            end
            S_B_FP: n_p = r_f_rd;
            S_T_RD: w_c_ra = {r_p, r_edge};
            S_T_D: begin
                if (r_c_rd == '0 && r_p != '0) begin
                    w_f_ra = r_p;
                end else begin
                    n_cursor = r_c_rd;
                    n_t      = r_c_rd;
                end
            end
            S_T_F: n_p = r_f_rd;
            S_C_NP: begin
                w_np_ra = r_t;
                w_f_ra  = r_t;
            end
            S_C_ND: begin
                n_nx   = r_f_rd;
                n_pidx = r_np_rd;
                if (r_np_rd != '0) w_cnt_ra = r_np_rd;
                else n_t = r_f_rd;
            end
            S_C_CNT: begin
                // saturate at all ones
                if (r_cnt_rd != '1) begin
                    w_cnt_we = 1'b1;
                    w_cnt_wa = r_pidx;
                    w_cnt_wd = r_cnt_rd + CW'(1);
                end
                n_t = r_nx;
            end
            S_R_A: w_cnt_ra = (r_a_rd != '0) ? r_a_rd : r_pidx;
            S_R_C: begin
                n_valid = 1'b1;
                n_count = r_cnt_rd;
                n_full  = r_ovf;
            end
            default: ;
        endcase
    end

    assign w_cnt64       = 64'(r_count);
    assign busy          = (r_state != S_IDLE);
    assign o_valid       = r_valid;
    assign o_match_count = w_cnt64[31:0];
    assign o_table_full  = r_full;

endmodule

// ===== tb/dna_multi_pattern_match_counter_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dna_multi_pattern_match_counter_tb
// Drives pattern loads, link builds, text walks, reads and clears into the
// counter and checks every read result against an in-bench Aho-Corasick model.
// ----------------------------------------------------------------------------
module dna_multi_pattern_match_counter_tb;
    import dnamc_pkg::*;

    localparam int NODE_CAP = 4096;
    localparam int PAT_CAP  = 1024;

    typedef struct {
        logic [2:0]  action;
        logic [7:0]  char_code;
        logic        pattern_end;
        logic [10:0] pattern_number;
    } t_item;

    typedef struct {
        logic [31:0] match_count;
        logic        table_full;
    } t_count_read;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  i_action;
    logic [7:0]  i_char_code;
    logic        i_pattern_end;
    logic [10:0] i_pattern_number;
    logic        o_valid;
    logic [31:0] o_match_count;
    logic        o_table_full;

    dna_multi_pattern_match_counter dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_action        (i_action),
        .i_char_code     (i_char_code),
        .i_pattern_end   (i_pattern_end),
        .i_pattern_number(i_pattern_number),
        .o_valid         (o_valid),
        .o_match_count   (o_match_count),
        .o_table_full    (o_table_full)
    );

    // automaton model
    logic [11:0] trie_child [NODE_CAP*4];
    logic [11:0] trie_fail  [NODE_CAP];
    logic [10:0] ends_here  [NODE_CAP];
    logic [10:0] dup_of     [PAT_CAP+1];
    logic [31:0] hits       [PAT_CAP+1];
    logic [12:0] node_total;
    logic [10:0] pat_total;
    logic [11:0] walk_node;
    logic        table_over;
    logic [11:0] ins_node;
    logic        ins_dropped;

    t_item       pending_items[$];
    t_count_read count_reads[$];
    int          idle_pct;
    int          errors;
    bit          hold_sender;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic logic [1:0] letter_to_edge(logic [7:0] ch);
        if (ch == CH_A) return EDGE_A;
        if (ch == CH_T) return EDGE_T;
        if (ch == CH_G) return EDGE_G;
        return EDGE_OTHER;
    endfunction

    function automatic void wipe_automaton();
        foreach (trie_child[i]) trie_child[i] = '0;
        foreach (trie_fail[i]) trie_fail[i] = '0;
        foreach (ends_here[i]) ends_here[i] = '0;
        foreach (dup_of[i]) dup_of[i] = '0;
        foreach (hits[i]) hits[i] = '0;
        node_total  = 13'd1;
        pat_total   = '0;
        walk_node   = '0;
        table_over  = 1'b0;
        ins_node    = '0;
        ins_dropped = 1'b0;
    endfunction

    function automatic void insert_char(logic [7:0] ch, logic last);
        logic [1:0]  k;
        logic [11:0] nx;
        k = letter_to_edge(ch);
        if (!ins_dropped) begin
            nx = trie_child[ins_node*4 + k];
            if (nx == 0) begin
                if (node_total < NODE_CAP) begin
                    nx = node_total[11:0];
                    node_total = node_total + 1;
                    trie_child[ins_node*4 + k] = nx;
                    trie_fail[nx] = '0;
                    ends_here[nx] = '0;
                    for (int j = 0; j < 4; j++) trie_child[nx*4 + j] = '0;
                end else begin
                    table_over  = 1'b1;
                    ins_dropped = 1'b1;
                end
            end
            if (!ins_dropped) ins_node = nx;
        end
        if (last) begin
            if (pat_total >= PAT_CAP) begin
                table_over = 1'b1;
            end else begin
                pat_total = pat_total + 1;
                dup_of[pat_total] = '0;
                if (!ins_dropped) begin
                    if (ends_here[ins_node] != 0) dup_of[pat_total] = ends_here[ins_node];
                    else ends_here[ins_node] = pat_total;
                end
            end
            ins_node    = '0;
            ins_dropped = 1'b0;
        end
    endfunction

    function automatic void link_failures();
        logic [11:0] bfs[$];
        logic [11:0] u, c, p, t;
        bfs.push_back('0);
        while (bfs.size() > 0) begin
            u = bfs.pop_front();
            for (int i = 0; i < 4; i++) begin
                c = trie_child[u*4 + i];
                if (c == 0) continue;
                trie_fail[c] = '0;
                if (u != 0) begin
                    p = trie_fail[u];
                    forever begin
                        t = trie_child[p*4 + i];
                        if (t != 0) begin
                            trie_fail[c] = t;
                            break;
                        end
                        if (p == 0) break;
                        p = trie_fail[p];
                    end
                end
                bfs.push_back(c);
            end
        end
        walk_node = '0;
    endfunction

    function automatic void walk_text(logic [7:0] ch);
        logic [1:0]  k;
        logic [11:0] p;
        if (ch < CH_A || ch > CH_Z) begin
            walk_node = '0;
            return;
        end
        k = letter_to_edge(ch);
        p = walk_node;
        while (trie_child[p*4 + k] == 0 && p != 0) p = trie_fail[p];
        p = trie_child[p*4 + k];
        walk_node = p;
        for (logic [11:0] t = p; t != 0; t = trie_fail[t])
            if (ends_here[t] != 0 && hits[ends_here[t]] != 32'hFFFF_FFFF)
                hits[ends_here[t]] = hits[ends_here[t]] + 1;
    endfunction

    function automatic void apply_item(t_item it);
        t_count_read r;
        logic [10:0] idx;
        case (it.action)
            ACT_PATTERN_CHAR: insert_char(it.char_code, it.pattern_end);
            ACT_BUILD:        link_failures();
            ACT_TEXT_CHAR:    walk_text(it.char_code);
            ACT_CLEAR:        wipe_automaton();
            ACT_READ: begin
                r.match_count = '0;
                idx = it.pattern_number;
                if (idx >= 1 && idx <= pat_total) begin
                    if (dup_of[idx] != 0) idx = dup_of[idx];
                    r.match_count = hits[idx];
                end
                r.table_full = table_over;
                count_reads.push_back(r);
            end
            default: ;
        endcase
    endfunction

    // driver: accept on start && !busy, then present the next item or idle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                apply_item(pending_items.pop_front());
            end
            if (!(start && busy)) begin
                if (pending_items.size() > 0 && !hold_sender
                        && $urandom_range(99) >= idle_pct) begin
                    start            <= 1'b1;
                    i_action         <= pending_items[0].action;
                    i_char_code      <= pending_items[0].char_code;
                    i_pattern_end    <= pending_items[0].pattern_end;
                    i_pattern_number <= pending_items[0].pattern_number;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_count_read want;
        if (i_rst_n && o_valid) begin
            if (count_reads.size() == 0) begin
                $error("unexpected read result: match_count=%0d", o_match_count);
                errors++;
            end else begin
                want = count_reads.pop_front();
                if (o_match_count !== want.match_count) begin
                    $error("match_count: expected %0d, actual %0d",
                           want.match_count, o_match_count);
                    errors++;
                end
                if (o_table_full !== want.table_full) begin
                    $error("table_full: expected %0d, actual %0d",
                           want.table_full, o_table_full);
                    errors++;
                end
            end
        end
    end

    task automatic push_op(logic [2:0] act, logic [7:0] ch = 8'h00, logic last = 1'b0,
                           logic [10:0] num = 11'd0);
        t_item it;
        it.action         = act;
        it.char_code      = ch;
        it.pattern_end    = last;
        it.pattern_number = num;
        pending_items.push_back(it);
    endtask

    function automatic logic [7:0] random_base();
        int r;
        r = $urandom_range(99);
        if (r < 30) return CH_A;
        if (r < 60) return CH_T;
        if (r < 88) return CH_G;
        if (r < 94) return 8'($urandom_range(CH_A, CH_Z));
        return 8'($urandom);
    endfunction

    task automatic push_pattern(int len);
        for (int i = 0; i < len; i++)
            push_op(ACT_PATTERN_CHAR, random_base(), i == len - 1, 11'($urandom));
    endtask

    // one case: clear, load patterns, usually build, walk text with extra ops mixed in, read counts
    task automatic push_case();
        int n_pat;
        n_pat = $urandom_range(1, 8);
        push_op(ACT_CLEAR);
        for (int i = 0; i < n_pat; i++) push_pattern($urandom_range(1, 4));
        if ($urandom_range(9) != 0) push_op(ACT_BUILD);
        for (int i = 0; i < $urandom_range(20, 50); i++) begin
            push_op(ACT_TEXT_CHAR, random_base(), 1'($urandom), 11'($urandom));
            if ($urandom_range(19) == 0) push_op(ACT_READ, 8'($urandom), 1'($urandom),
                                                 11'($urandom_range(0, n_pat + 1)));
            if ($urandom_range(39) == 0) push_op(3'($urandom_range(5, 7)), 8'($urandom));
            if ($urandom_range(59) == 0) push_pattern($urandom_range(1, 3));
            if ($urandom_range(79) == 0) push_op(ACT_BUILD);
        end
        for (int i = 0; i <= n_pat + 1; i++) push_op(ACT_READ, 8'($urandom), 1'($urandom),
                                                     11'(i));
        push_op(ACT_READ, 8'h00, 1'b0, 11'($urandom));
    endtask

    task automatic drain();
        wait (pending_items.size() == 0 && count_reads.size() == 0);
        @(posedge i_clk);
        wait (!busy);
        @(posedge i_clk);
    endtask

    initial begin
        errors      = 0;
        idle_pct    = 11;
        hold_sender = 1'b0;
        start       = 1'b0;
        i_action    = ACT_CLEAR;
        i_char_code = '0;
        i_pattern_end    = 1'b0;
        i_pattern_number = '0;
        wipe_automaton();
        i_rst_n = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: out-of-range reads, duplicate pattern, odd letters, lowercase
        push_op(ACT_READ, 8'h00, 1'b0, 11'd0);
        push_op(ACT_READ, 8'hFF, 1'b1, 11'd2047);
        push_op(ACT_PATTERN_CHAR, CH_A);
        push_op(ACT_PATTERN_CHAR, CH_T, 1'b1);
        push_op(ACT_PATTERN_CHAR, CH_T, 1'b1);
        push_op(ACT_PATTERN_CHAR, CH_A);
        push_op(ACT_PATTERN_CHAR, CH_T, 1'b1);
        push_op(ACT_PATTERN_CHAR, 8'h43);
        push_op(ACT_PATTERN_CHAR, 8'hFF, 1'b1);
        push_op(ACT_TEXT_CHAR, CH_T);
        push_op(ACT_BUILD);
        push_op(ACT_TEXT_CHAR, CH_A);
        push_op(ACT_TEXT_CHAR, CH_T);
        push_op(ACT_TEXT_CHAR, 8'h61);
        push_op(ACT_TEXT_CHAR, CH_Z);
        push_op(ACT_TEXT_CHAR, 8'h43);
        push_op(ACT_TEXT_CHAR, 8'hFF);
        push_op(ACT_TEXT_CHAR, 8'h40);
        for (int i = 1; i <= 5; i++) push_op(ACT_READ, 8'h00, 1'b0, 11'(i));
        push_op(3'd5);
        push_op(3'd6);
        push_op(3'd7);
        drain();

        for (int ph = 0; ph < 3; ph++) begin
            idle_pct = (ph == 0) ? 11 : (ph == 1) ? 70 : 0;
            for (int c = 0; c < 2; c++) push_case();
            if (ph == 1) begin
                // hold the sender until every read result is back
                wait (count_reads.size() > 0);
                hold_sender = 1'b1;
                wait (count_reads.size() == 0);
                hold_sender = 1'b0;
            end
            drain();
        end

        // fill the pattern table past its limit
        idle_pct = 0;
        push_op(ACT_CLEAR);
        for (int i = 0; i < 1026; i++)
            push_op(ACT_PATTERN_CHAR, 8'($urandom), 1'b1);
        push_op(ACT_BUILD);
        for (int i = 0; i < 20; i++) push_op(ACT_TEXT_CHAR, 8'($urandom_range(CH_A, CH_Z)));
        for (int i = 0; i < 20; i++) push_op(ACT_READ, 8'h00, 1'b0, 11'($urandom));
        push_op(ACT_READ, 8'h00, 1'b0, 11'd1024);
        push_op(ACT_READ, 8'h00, 1'b0, 11'd1025);
        drain();

        repeat (200) @(posedge i_clk);
        if (errors == 0 && count_reads.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin
        #30ms;
        $display("simulation failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/dnamc_pkg.sv
rtl/dna_multi_pattern_match_counter.sv
tb/dna_multi_pattern_match_counter_tb.sv
